// File: rtl/oaht_pkg.sv
// Shared types and constants for the open-address hash table unit.
// No dependencies.
package oaht_pkg;

    localparam int LOG2_CAPACITY  = 8;
    localparam int KEY_WIDTH      = 32;
    localparam int VALUE_WIDTH    = 32;
    localparam int FILL_RATIO_NUM = 3;
    localparam int FILL_RATIO_DEN = 4;
    localparam int CAPACITY       = 1 << LOG2_CAPACITY;
    localparam int MAX_RESET_RAW  = (CAPACITY * FILL_RATIO_NUM) / FILL_RATIO_DEN;
    localparam int MAX_RESET      = (MAX_RESET_RAW > 255) ? 255 : MAX_RESET_RAW;
    localparam int ENTRY_WIDTH    = KEY_WIDTH + 32 + VALUE_WIDTH;

    typedef logic [LOG2_CAPACITY-1:0] slot_idx_t;
    typedef logic [LOG2_CAPACITY:0]   step_cnt_t;

    typedef enum logic [1:0] {
        ST_ABSENT  = 2'd0,
        ST_DELETED = 2'd1,
        ST_PRESENT = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_FULL      = 2'd2
    } result_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_OUT
    } fsm_state_t;

endpackage

// File: rtl/open_address_hash_table_unit.sv
// Top level of the open-address hash table unit: control sequencer and
// status/entry memories. Depends on oaht_pkg and oaht_ram.
//
// Usage: input items (action, key, hash, value) arrive on in_valid/in_ready;
// one result item per input leaves on out_valid/out_ready. max_entries is
// written through cfg_we/cfg_data; the user must write it only while no
// item is in flight; the unit leaves this check to the user.
// Each item walks its triangular probe sequence, one slot per memory read;
// a probe step is a status and entry RAM read, then a compare, and any
// table update is written in the compare cycle of the last step. After
// the last compare the unit passes through S_WRITE to S_OUT, where
// out_valid is high; a probe is bounded to CAPACITY steps. A clear sweeps
// all CAPACITY slots, one per cycle, and then presents its result. Items
// are processed one at a time: in_ready returns the cycle after the result
// item is taken. After reset the unit clears the status memory before
// in_ready rises; max_entries returns to 192 and the count to zero.
// The result is held in an output register; while the receiver stalls
// the unit holds the result and accepts no new item.
module open_address_hash_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] key,
    input  logic [31:0] hash,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        created,
    output logic [31:0] found_value,
    output logic [7:0]  slot,
    output logic [7:0]  entry_count,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data
);
    import oaht_pkg::*;

    fsm_state_t state_reg, state_next;

    logic [1:0]             act_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [31:0]            hash_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    slot_idx_t              pos_reg, pos_next;
    slot_idx_t              delta_reg;
    step_cnt_t              steps_reg;
    logic                   have_del_reg;
    slot_idx_t              del_slot_reg;
    logic [7:0]             max_reg;
    logic [7:0]             count_reg, count_next;

    logic [1:0]  res_status_reg, res_status_next;
    logic        res_created_reg, res_created_next;
    logic [31:0] res_found_reg, res_found_next;
    logic [7:0]  res_slot_reg, res_slot_next;

    // write-back to memories
    logic             st_we, en_we;
    slot_idx_t        wr_addr;
    logic [1:0]       st_wdata;
    logic [ENTRY_WIDTH-1:0] en_wdata;

    logic [1:0]             st_rdata;
    logic [ENTRY_WIDTH-1:0] en_rdata;
    slot_idx_t              raddr;

    logic [KEY_WIDTH-1:0]   rd_key;
    logic [31:0]            rd_hash;
    logic [VALUE_WIDTH-1:0] rd_val;
    logic                   match, last_step;

    oaht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_status_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (wr_addr),
        .wdata (st_wdata),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    oaht_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(CAPACITY)) u_entry_ram (
        .clk   (clk),
        .we    (en_we),
        .waddr (wr_addr),
        .wdata (en_wdata),
        .raddr (raddr),
        .rdata (en_rdata)
    );

    assign raddr = pos_reg;
    assign {rd_key, rd_hash, rd_val} = en_rdata;
    assign match = (st_rdata == ST_PRESENT) && (rd_hash == hash_reg) && (rd_key == key_reg);
    assign last_step = (steps_reg == step_cnt_t'(CAPACITY - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (pos_reg == slot_idx_t'(CAPACITY - 1))
                begin
                    // the sweep after reset has no result item
                    state_next = (act_reg == ACT_CLEAR) ? S_OUT : S_IDLE;
                end
            S_IDLE:
                if (in_valid)
                begin
                    state_next = (action_t'(action) == ACT_CLEAR) ? S_CLEAR : S_READ;
                end
            S_READ:  state_next = S_CHECK;
            S_CHECK:
            begin
                if (match || st_rdata == ST_ABSENT || last_step)
                    state_next = S_WRITE;
                else
                    state_next = S_READ;
            end
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath decisions in CLEAR, IDLE and CHECK
    always_comb
    begin
        logic      done;
        logic      free_ok;
        slot_idx_t free_slot;
        done      = match || st_rdata == ST_ABSENT || last_step;
        free_ok   = have_del_reg || st_rdata == ST_ABSENT || st_rdata == ST_DELETED;
        free_slot = have_del_reg ? del_slot_reg : pos_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_created_next = res_created_reg;
        res_found_next  = res_found_reg;
        res_slot_next   = res_slot_reg;
        st_we    = 1'b0;
        en_we    = 1'b0;
        wr_addr  = pos_reg;
        st_wdata = ST_ABSENT;
        en_wdata = {key_reg, hash_reg, val_reg};
        case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                wr_addr  = pos_reg;
                pos_next = pos_reg + 1'b1;
            end
            S_IDLE:
            begin
                pos_next = slot_idx_t'(hash[LOG2_CAPACITY-1:0]);
                if (in_valid && action_t'(action) == ACT_CLEAR)
                begin
                    pos_next         = '0;
                    count_next       = '0;
                    res_status_next  = RES_OK;
                    res_created_next = 1'b0;
                    res_found_next   = '0;
                    res_slot_next    = '0;
                end
            end
            S_CHECK:
            begin
                pos_next = pos_reg + delta_reg;
                if (done)
                begin
                    res_status_next  = RES_OK;
                    res_created_next = 1'b0;
                    res_found_next   = '0;
                    res_slot_next    = '0;
                    case (action_t'(act_reg))
                        ACT_LOOKUP:
                            if (match)
                            begin
                                res_found_next = 32'(rd_val);
                                res_slot_next  = 8'(pos_reg);
                            end
                            else res_status_next = RES_NOT_FOUND;
                        ACT_INSERT:
                            if (match)
                            begin
                                en_we         = 1'b1;
                                en_wdata      = {rd_key, rd_hash, val_reg};
                                res_slot_next = 8'(pos_reg);
                            end
                            else if ({1'b0, count_reg} + 9'd1 > {1'b0, max_reg} || !free_ok)
                                res_status_next = RES_FULL;
                            else
                            begin
                                st_we            = 1'b1;
                                en_we            = 1'b1;
                                wr_addr          = free_slot;
                                st_wdata         = ST_PRESENT;
                                count_next       = count_reg + 8'd1;
                                res_created_next = 1'b1;
                                res_slot_next    = 8'(free_slot);
                            end
                        ACT_REMOVE:
                            if (match)
                            begin
                                st_we          = 1'b1;
                                st_wdata       = ST_DELETED;
                                res_found_next = 32'(rd_val);
                                res_slot_next  = 8'(pos_reg);
                                if (count_reg != 8'd0) count_next = count_reg - 8'd1;
                            end
                            else res_status_next = RES_NOT_FOUND;
                        default: res_status_next = RES_OK;
                    endcase
                end
            end
            default: pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            pos_reg         <= '0;
            delta_reg       <= '0;
            steps_reg       <= '0;
            have_del_reg    <= 1'b0;
            del_slot_reg    <= '0;
            max_reg         <= 8'(MAX_RESET);
            count_reg       <= '0;
            res_status_reg  <= '0;
            res_created_reg <= 1'b0;
            res_found_reg   <= '0;
            res_slot_reg    <= '0;
            act_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            count_reg       <= count_next;
            res_status_reg  <= res_status_next;
            res_created_reg <= res_created_next;
            res_found_reg   <= res_found_next;
            res_slot_reg    <= res_slot_next;
            if (cfg_we) max_reg <= cfg_data;
            if (state_reg == S_IDLE && in_valid)
            begin
                act_reg      <= action;
                delta_reg    <= slot_idx_t'(1);
                steps_reg    <= '0;
                have_del_reg <= 1'b0;
            end
            if (state_reg == S_CHECK)
            begin
                delta_reg <= delta_reg + 1'b1;
                steps_reg <= steps_reg + 1'b1;
                if (st_rdata == ST_DELETED && !have_del_reg)
                begin
                    have_del_reg <= 1'b1;
                    del_slot_reg <= pos_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            key_reg  <= KEY_WIDTH'(key);
            hash_reg <= hash;
            val_reg  <= VALUE_WIDTH'(value);
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign status      = res_status_reg;
    assign created     = res_created_reg;
    assign found_value = res_found_reg;
    assign slot        = res_slot_reg;
    assign entry_count = count_reg;

endmodule

// File: rtl/oaht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
